// ===== design/r2hsv_pkg.sv =====
// r2hsv_pkg: shared types, constants and codes for the RGB to HSV pixel converter.
// Used by every module in the design folder; depends on nothing else.

package r2hsv_pkg;

    // Fractional bits of the hue output (degrees times 2^HUE_FRAC_BITS), range 0 to 6.
    localparam int HUE_FRAC_BITS = 6;

    localparam int CHAN_W = 8;
    localparam int HUE_W  = 15;

    localparam int HUE_ONE  = 1 << HUE_FRAC_BITS;
    localparam int HUE_SPAN = 60 * HUE_ONE;
    localparam int HUE_FULL = 360 * HUE_ONE;

    // Quotient bits: enough for the hue fraction (up to 60 degrees) and for saturation.
    localparam int HQ_W = $clog2(HUE_SPAN + 1);
    localparam int Q_W  = (HQ_W > CHAN_W) ? HQ_W : CHAN_W;

    // Partial remainder: divisor shifted by the quotient width.
    localparam int REM_W = CHAN_W + Q_W;

    // Signed working width of the hue sum, room for 360 degrees plus a sign.
    localparam int HUE_SUM_W = $clog2(HUE_FULL) + 2;

    typedef enum logic [1:0] {
        SEC_RED   = 2'd0,
        SEC_GREEN = 2'd1,
        SEC_BLUE  = 2'd2
    } t_sector;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } t_pix_in;

    typedef struct packed {
        logic [HUE_W-1:0]  hue;
        logic              hue_defined;
        logic [CHAN_W-1:0] saturation;
        logic [CHAN_W-1:0] brightness;
    } t_pix_out;

    // Fields that ride along the divider chain unchanged.
    typedef struct packed {
        t_sector           sector;
        logic              negative;
        logic              defined;
        logic              max_zero;
        logic [CHAN_W-1:0] brightness;
    } t_side;

    // State of one item inside the divider chain: two divisions side by side.
    typedef struct packed {
        logic [REM_W-1:0]  hue_rem;
        logic [REM_W-1:0]  sat_rem;
        logic [CHAN_W-1:0] hue_div;
        logic [CHAN_W-1:0] sat_div;
        logic [Q_W-1:0]    hue_q;
        logic [Q_W-1:0]    sat_q;
        t_side             side;
    } t_div_cell;

endpackage

// ===== design/r2hsv_front.sv =====
// r2hsv_front: first stage; finds max, min, sector and the dividends of both divisions.
// Depends on r2hsv_pkg.

module r2hsv_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  r2hsv_pkg::t_pix_in   i_pix,
    output logic                 o_valid,
    input  logic                 i_stall,
    output r2hsv_pkg::t_div_cell o_cell
);
    import r2hsv_pkg::*;

    logic                r_valid;
    t_div_cell           r_cell;
    t_div_cell           n_cell;
    t_sector             sector;
    logic [CHAN_W-1:0]   mx;
    logic [CHAN_W-1:0]   mn;
    logic [CHAN_W-1:0]   delta;
    logic signed [CHAN_W:0] diff;
    logic [CHAN_W-1:0]   abs_diff;
    logic [2*CHAN_W-1:0] sat_num;

    always_comb begin
        // Red wins ties over green, green over blue.
        if (i_pix.red >= i_pix.green && i_pix.red >= i_pix.blue) begin
            sector = SEC_RED;
            mx     = i_pix.red;
            diff   = $signed({1'b0, i_pix.green}) - $signed({1'b0, i_pix.blue});
        end else if (i_pix.green >= i_pix.blue) begin
            sector = SEC_GREEN;
            mx     = i_pix.green;
            diff   = $signed({1'b0, i_pix.blue}) - $signed({1'b0, i_pix.red});
        end else begin
            sector = SEC_BLUE;
            mx     = i_pix.blue;
            diff   = $signed({1'b0, i_pix.red}) - $signed({1'b0, i_pix.green});
        end

        mn = i_pix.red;
        if (i_pix.green < mn) mn = i_pix.green;
        if (i_pix.blue < mn)  mn = i_pix.blue;
        delta = mx - mn;

        abs_diff = diff[CHAN_W] ? CHAN_W'(-diff) : diff[CHAN_W-1:0];
        // 255 * delta as delta * 256 - delta.
        sat_num  = {delta, {CHAN_W{1'b0}}} - {{CHAN_W{1'b0}}, delta};

        n_cell.hue_rem = REM_W'(HUE_SPAN) * REM_W'(abs_diff);
        n_cell.sat_rem = REM_W'(sat_num);
        n_cell.hue_div = delta;
        n_cell.sat_div = mx;
        n_cell.hue_q   = '0;
        n_cell.sat_q   = '0;
        n_cell.side.sector     = sector;
        n_cell.side.negative   = diff[CHAN_W];
        n_cell.side.defined    = (mx != '0) && (delta != '0);
        n_cell.side.max_zero   = (mx == '0);
        n_cell.side.brightness = mx;
    end

    assign o_stall = r_valid && i_stall;
    assign o_valid = r_valid;
    assign o_cell  = r_cell;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_stall) begin
            r_valid <= i_valid;
        end
        if (!o_stall && i_valid) begin
            r_cell <= n_cell;
        end
    end

endmodule

// ===== design/r2hsv_div_cell.sv =====
// r2hsv_div_cell: one restoring-division step for hue and saturation, one quotient bit each.
// Depends on r2hsv_pkg.

module r2hsv_div_cell (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  r2hsv_pkg::t_div_cell i_cell,
    output logic                 o_valid,
    input  logic                 i_stall,
    output r2hsv_pkg::t_div_cell o_cell
);
    import r2hsv_pkg::*;

    logic             r_valid;
    t_div_cell        r_cell;
    t_div_cell        n_cell;
    logic [REM_W-1:0] hue_shift;
    logic [REM_W-1:0] sat_shift;
    logic [REM_W-1:0] hue_left;
    logic [REM_W-1:0] sat_left;
    logic             hue_take;
    logic             sat_take;

    always_comb begin
        hue_shift = {1'b0, i_cell.hue_div, {(Q_W-1){1'b0}}};
        sat_shift = {1'b0, i_cell.sat_div, {(Q_W-1){1'b0}}};
        hue_take  = i_cell.hue_rem >= hue_shift;
        sat_take  = i_cell.sat_rem >= sat_shift;
        hue_left  = hue_take ? i_cell.hue_rem - hue_shift : i_cell.hue_rem;
        sat_left  = sat_take ? i_cell.sat_rem - sat_shift : i_cell.sat_rem;

        n_cell         = i_cell;
        // Remainder stays below the shifted divisor, so the top bit drops safely.
        n_cell.hue_rem = {hue_left[REM_W-2:0], 1'b0};
        n_cell.sat_rem = {sat_left[REM_W-2:0], 1'b0};
        n_cell.hue_q   = {i_cell.hue_q[Q_W-2:0], hue_take};
        n_cell.sat_q   = {i_cell.sat_q[Q_W-2:0], sat_take};
    end

    assign o_stall = r_valid && i_stall;
    assign o_valid = r_valid;
    assign o_cell  = r_cell;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_stall) begin
            r_valid <= i_valid;
        end
        if (!o_stall && i_valid) begin
            r_cell <= n_cell;
        end
    end

endmodule

// ===== design/r2hsv_back.sv =====
// r2hsv_back: last stage; adds the sector offset, wraps hue and registers the result item.
// Depends on r2hsv_pkg.

module r2hsv_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  r2hsv_pkg::t_div_cell i_cell,
    output logic                 o_valid,
    input  logic                 i_stall,
    output r2hsv_pkg::t_pix_out  o_hsv
);
    import r2hsv_pkg::*;

    logic                        r_valid;
    t_pix_out                    r_hsv;
    t_pix_out                    n_hsv;
    logic signed [HUE_SUM_W-1:0] offset;
    logic signed [HUE_SUM_W-1:0] frac;
    logic signed [HUE_SUM_W-1:0] sum;
    logic signed [HUE_SUM_W-1:0] wrapped;

    always_comb begin
        case (i_cell.side.sector)
            SEC_RED:   offset = '0;
            SEC_GREEN: offset = HUE_SUM_W'(120 * HUE_ONE);
            SEC_BLUE:  offset = HUE_SUM_W'(240 * HUE_ONE);
            default:   offset = '0;
        endcase

        frac    = $signed(HUE_SUM_W'(i_cell.hue_q));
        sum     = i_cell.side.negative ? offset - frac : offset + frac;
        wrapped = sum[HUE_SUM_W-1] ? sum + HUE_SUM_W'(HUE_FULL) : sum;

        n_hsv.hue         = i_cell.side.defined ? HUE_W'(wrapped[HUE_SUM_W-2:0]) : '0;
        n_hsv.hue_defined = i_cell.side.defined;
        n_hsv.saturation  = i_cell.side.max_zero ? '0 : i_cell.sat_q[CHAN_W-1:0];
        n_hsv.brightness  = i_cell.side.brightness;
    end

    assign o_stall = r_valid && i_stall;
    assign o_valid = r_valid;
    assign o_hsv   = r_hsv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_stall) begin
            r_valid <= i_valid;
        end
        if (!o_stall && i_valid) begin
            r_hsv <= n_hsv;
        end
    end

endmodule

// ===== design/rgb_to_hsv_pixel.sv =====
// rgb_to_hsv_pixel: top level of the RGB to HSV pixel converter.
// Depends on r2hsv_pkg, r2hsv_front, r2hsv_div_cell and r2hsv_back.

// Converts one 8-bit RGB pixel per item into hue (degrees times 2^HUE_FRAC_BITS),
// a hue-defined flag, saturation floor(255*delta/max) and brightness (the largest
// channel). Black and gray pixels give hue 0 with hue_defined low. The block takes
// one item every clock while o_stall is low and keeps up to Q_W+2 items in flight
// (14 at the default of six hue fraction bits): a front stage, a chain of Q_W
// division cells that each produce one quotient bit of both divisions, and a
// result register. Each item passes through them in that order. Every stage holds
// its own valid bit, so a stall at the output only backs up into stages that hold
// an item; empty stages keep filling. Reset is synchronous, active low, and clears
// the valid bits only.

module rgb_to_hsv_pixel (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  r2hsv_pkg::t_pix_in  i_pix,
    output logic                o_valid,
    input  logic                i_stall,
    output r2hsv_pkg::t_pix_out o_hsv
);
    import r2hsv_pkg::*;

    // Links between stages; link k feeds division cell k.
    t_div_cell link_cell  [Q_W+1];
    logic      link_valid [Q_W+1];
    logic      link_stall [Q_W+1];

    // Find max, min, sector and the two dividends.
    r2hsv_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_pix   (i_pix),
        .o_valid (link_valid[0]),
        .i_stall (link_stall[0]),
        .o_cell  (link_cell[0])
    );

    // Advance each item one quotient bit per cell, most significant bit first.
    for (genvar k = 0; k < Q_W; k++) begin : g_cell
        r2hsv_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (link_valid[k]),
            .o_stall (link_stall[k]),
            .i_cell  (link_cell[k]),
            .o_valid (link_valid[k+1]),
            .i_stall (link_stall[k+1]),
            .o_cell  (link_cell[k+1])
        );
    end

    // Add the sector offset, wrap negative hue, hold the result item.
    r2hsv_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (link_valid[Q_W]),
        .o_stall (link_stall[Q_W]),
        .i_cell  (link_cell[Q_W]),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_hsv   (o_hsv)
    );

endmodule

// ===== tb/tb_rgb_to_hsv_pixel.sv =====
// tb_rgb_to_hsv_pixel: self-checking testbench for the RGB to HSV pixel converter.
// Depends on r2hsv_pkg and rgb_to_hsv_pixel; runs a directed table, then random pixels,
// and checks every result against a typed result or a local conversion model.
`timescale 1ns / 100ps

module tb_rgb_to_hsv_pixel;

    import r2hsv_pkg::*;

    // Cycles to wait after the last result, from the pipeline depth plus margin.
    localparam int TAIL_CYCLES = Q_W + 2 + 8;
    // Cycles without any handshake before the run is declared hung.
    localparam int HANG_LIMIT  = 4000;
    localparam int RAND_ITEMS  = 900;
    // Percent chance of a sender gap or a receiver stall on any cycle outside the calm stretch.
    localparam int IDLE_PCT    = 15;

    logic     i_clk   = 1'b0;
    logic     i_rst_n = 1'b0;
    logic     i_valid = 1'b0;
    logic     i_stall = 1'b0;
    t_pix_in  i_pix   = '0;
    logic     o_stall;
    logic     o_valid;
    t_pix_out o_hsv;

    // Expected results, oldest first.
    t_pix_out hsv_expected[$];

    // Directed table: pixel, whether the result is typed in, and that result.
    t_pix_in  dir_pix[$];
    bit       dir_typed[$];
    t_pix_out dir_hsv[$];

    int       err_count   = 0;
    int       quiet_cycles = 0;
    bit       calm        = 1'b0;   // high while neither side may idle
    t_pix_in  pix;
    t_pix_out hsv_want;
    int       mode;
    int       lvl;

    rgb_to_hsv_pixel dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_pix   (i_pix),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_hsv   (o_hsv)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Convert one pixel the way the block must: max, min, delta, then two divisions.
    function automatic t_pix_out convert_pixel(input t_pix_in p);
        int r, g, b, mx, mn, delta, diff, offset_deg, h;
        t_pix_out res;
        r = int'(p.red);
        g = int'(p.green);
        b = int'(p.blue);
        mx = r;
        mn = r;
        if (g > mx) mx = g;
        if (b > mx) mx = b;
        if (g < mn) mn = g;
        if (b < mn) mn = b;
        delta = mx - mn;
        res = '0;
        res.brightness = mx[CHAN_W-1:0];
        if (mx != 0) begin
            h = (255 * delta) / mx;
            res.saturation = h[CHAN_W-1:0];
        end
        if (mx != 0 && delta != 0) begin
            res.hue_defined = 1'b1;
            // Ties go red first, then green.
            if (r == mx) begin
                offset_deg = 0;
                diff = g - b;
            end else if (g == mx) begin
                offset_deg = 120;
                diff = b - r;
            end else begin
                offset_deg = 240;
                diff = r - g;
            end
            // SystemVerilog signed division truncates toward zero.
            h = offset_deg * HUE_ONE + (60 * HUE_ONE * diff) / delta;
            if (h < 0) h += 360 * HUE_ONE;
            res.hue = h[HUE_W-1:0];
        end
        return res;
    endfunction

    task automatic add_row(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
                           input bit typed, input logic [HUE_W-1:0] hue,
                           input logic defd, input logic [7:0] sat,
                           input logic [7:0] bright);
        t_pix_in  p;
        t_pix_out q;
        p.red = r;
        p.green = g;
        p.blue = b;
        q.hue = hue;
        q.hue_defined = defd;
        q.saturation = sat;
        q.brightness = bright;
        dir_pix.push_back(p);
        dir_typed.push_back(typed);
        dir_hsv.push_back(q);
    endtask

    // Offer one item; entered and left at a falling edge. Record its result on acceptance.
    task automatic send_pixel(input t_pix_in p, input t_pix_out want);
        while (!calm && $urandom_range(99) < IDLE_PCT) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_pix   <= p;
        // Hold the item until a rising edge finds the block not stalled.
        do @(posedge i_clk); while (o_stall);
        hsv_expected.push_back(want);
        @(negedge i_clk);
    endtask

    // Hold off the sender until every outstanding result has arrived.
    task automatic drain_results();
        i_valid <= 1'b0;
        @(negedge i_clk);
        while (hsv_expected.size() != 0) @(negedge i_clk);
    endtask

    // Receiver: stall at random, except in the calm stretch.
    always @(negedge i_clk) begin
        i_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
    end

    // Check each accepted result against the oldest expectation, field by field.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (hsv_expected.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %h", $time, o_hsv);
                err_count++;
            end else begin
                hsv_want = hsv_expected.pop_front();
                if (o_hsv.hue !== hsv_want.hue) begin
                    $display("%0t: hue mismatch, expected %0d, actual %0d",
                             $time, hsv_want.hue, o_hsv.hue);
                    err_count++;
                end
                if (o_hsv.hue_defined !== hsv_want.hue_defined) begin
                    $display("%0t: hue_defined mismatch, expected %0d, actual %0d",
                             $time, hsv_want.hue_defined, o_hsv.hue_defined);
                    err_count++;
                end
                if (o_hsv.saturation !== hsv_want.saturation) begin
                    $display("%0t: saturation mismatch, expected %0d, actual %0d",
                             $time, hsv_want.saturation, o_hsv.saturation);
                    err_count++;
                end
                if (o_hsv.brightness !== hsv_want.brightness) begin
                    $display("%0t: brightness mismatch, expected %0d, actual %0d",
                             $time, hsv_want.brightness, o_hsv.brightness);
                    err_count++;
                end
            end
        end
    end

    // Watchdog: count cycles in which neither channel moves an item.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
                quiet_cycles <= 0;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
                if (quiet_cycles >= HANG_LIMIT) begin
                    $display("%0t: no handshake for %0d cycles", $time, HANG_LIMIT);
                    $display("TEST FAILED");
                    $finish;
                end
            end
        end
    end

    initial begin
        // Hold reset low at the start, release it at a falling edge.
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Black and gray: hue undefined and zero, saturation zero.
        add_row(8'd0,   8'd0,   8'd0,   1'b1, '0, 1'b0, 8'd0, 8'd0);
        add_row(8'd255, 8'd255, 8'd255, 1'b1, '0, 1'b0, 8'd0, 8'd255);
        add_row(8'd128, 8'd128, 8'd128, 1'b1, '0, 1'b0, 8'd0, 8'd128);
        add_row(8'd1,   8'd1,   8'd1,   1'b1, '0, 1'b0, 8'd0, 8'd1);
        // Pure primaries land on the sector offsets.
        add_row(8'd255, 8'd0,   8'd0,   1'b1, '0, 1'b1, 8'd255, 8'd255);
        add_row(8'd0,   8'd255, 8'd0,   1'b1, HUE_W'(120 * HUE_ONE), 1'b1, 8'd255, 8'd255);
        add_row(8'd0,   8'd0,   8'd255, 1'b1, HUE_W'(240 * HUE_ONE), 1'b1, 8'd255, 8'd255);
        // Secondaries and tied maxima: red beats green and blue, green beats blue.
        add_row(8'd255, 8'd255, 8'd0,   1'b0, '0, 1'b0, 8'd0, 8'd0);
        add_row(8'd0,   8'd255, 8'd255, 1'b0, '0, 1'b0, 8'd0, 8'd0);
        add_row(8'd255, 8'd0,   8'd255, 1'b0, '0, 1'b0, 8'd0, 8'd0);
        add_row(8'd10,  8'd200, 8'd200, 1'b0, '0, 1'b0, 8'd0, 8'd0);
        add_row(8'd200, 8'd10,  8'd200, 1'b0, '0, 1'b0, 8'd0, 8'd0);
        // Negative hue sum, wrapped up by 360 degrees.
        add_row(8'd255, 8'd0,   8'd1,   1'b0, '0, 1'b0, 8'd0, 8'd0);
        add_row(8'd200, 8'd10,  8'd50,  1'b0, '0, 1'b0, 8'd0, 8'd0);
        // Smallest nonzero maximum and smallest delta.
        add_row(8'd1,   8'd0,   8'd0,   1'b0, '0, 1'b0, 8'd0, 8'd0);
        add_row(8'd0,   8'd1,   8'd0,   1'b0, '0, 1'b0, 8'd0, 8'd0);
        add_row(8'd0,   8'd0,   8'd1,   1'b0, '0, 1'b0, 8'd0, 8'd0);
        add_row(8'd255, 8'd254, 8'd254, 1'b0, '0, 1'b0, 8'd0, 8'd0);
        add_row(8'd254, 8'd255, 8'd255, 1'b0, '0, 1'b0, 8'd0, 8'd0);
        add_row(8'd1,   8'd2,   8'd3,   1'b0, '0, 1'b0, 8'd0, 8'd0);
        // Alternating bit patterns on every channel.
        add_row(8'hAA,  8'h55,  8'h0F,  1'b0, '0, 1'b0, 8'd0, 8'd0);
        add_row(8'h55,  8'hAA,  8'hF0,  1'b0, '0, 1'b0, 8'd0, 8'd0);
        add_row(8'h0F,  8'hF0,  8'hAA,  1'b0, '0, 1'b0, 8'd0, 8'd0);

        // Walk the table; rows without a typed result go through the model.
        foreach (dir_pix[i]) begin
            send_pixel(dir_pix[i], dir_typed[i] ? dir_hsv[i] : convert_pixel(dir_pix[i]));
        end
        drain_results();

        for (int n = 0; n < RAND_ITEMS; n++) begin
            // Keep both sides busy without gaps for a long stretch.
            calm = (n >= 300 && n < 500);
            if (n == 600) drain_results();
            mode = $urandom_range(99);
            lvl  = $urandom_range(255);
            pix.red   = CHAN_W'($urandom_range(255));
            pix.green = CHAN_W'($urandom_range(255));
            pix.blue  = CHAN_W'($urandom_range(255));
            if (mode < 60) begin
                // Leave uniform pixels as drawn.
            end else if (mode < 70) begin
                // Gray or black: all channels equal.
                pix.red = lvl[CHAN_W-1:0];
                pix.green = lvl[CHAN_W-1:0];
                pix.blue = lvl[CHAN_W-1:0];
            end else if (mode < 85) begin
                // Tie two channels to stress the sector priority.
                case ($urandom_range(2))
                    0: pix.green = pix.red;
                    1: pix.blue = pix.green;
                    default: pix.blue = pix.red;
                endcase
            end else if (mode < 95) begin
                // Tiny channels: small max and delta.
                pix.red   = CHAN_W'($urandom_range(3));
                pix.green = CHAN_W'($urandom_range(3));
                pix.blue  = CHAN_W'($urandom_range(3));
            end else begin
                // Red and green at the rails, blue at the top rail or a random level.
                pix.red   = $urandom_range(1) ? 8'd255 : 8'd0;
                pix.green = $urandom_range(1) ? 8'd255 : 8'd0;
                pix.blue  = $urandom_range(1) ? 8'd255 : lvl[7:0];
            end
            send_pixel(pix, convert_pixel(pix));
        end
        calm = 1'b0;

        // Drop valid, let every result arrive, then watch for strays.
        drain_results();
        repeat (TAIL_CYCLES) @(negedge i_clk);

        if (err_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
